/* hw/rtl/round_robin_task_scheduler_macros.svh */
// Assertion macros for the round-robin task scheduler.
// Included by the RTL files that carry concurrent assertions.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rrts_pkg.sv */
// Shared types and constants for the round-robin task scheduler.
// No dependencies; used by the interfaces, the core and the top level.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int MODE_W        = 2;
  localparam int TICKS_W       = 32;
  localparam int NEXT_W        = 3;
  localparam int COUNT_W       = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_DELAY  = 2'd2,
    MODE_DONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [NEXT_W-1:0]  next_task;
    logic               switch_request;
    logic [COUNT_W-1:0] task_count;
    logic               create_error;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_sts_t;

endpackage

/* hw/rtl/rrts_in_if.sv */
// Input item channel of the round-robin task scheduler.
// Depends on rrts_pkg for the field widths.
`timescale 1ns / 1ps

interface rrts_in_if;
  logic                           valid;
  logic                           ready;
  logic [rrts_pkg::MODE_W-1:0]    mode;
  logic [rrts_pkg::TICKS_W-1:0]   delay_ticks;

  modport source (output valid, output mode, output delay_ticks, input ready);
  modport sink (input valid, input mode, input delay_ticks, output ready);
endinterface

/* hw/rtl/rrts_out_if.sv */
// Result item channel of the round-robin task scheduler.
// Depends on rrts_pkg for the field widths.
`timescale 1ns / 1ps

interface rrts_out_if;
  logic                           valid;
  logic                           ready;
  logic [rrts_pkg::NEXT_W-1:0]    next_task;
  logic                           switch_request;
  logic [rrts_pkg::COUNT_W-1:0]   task_count;
  logic                           create_error;

  modport source (output valid, output next_task, output switch_request,
                  output task_count, output create_error, input ready);
  modport sink (input valid, input next_task, input switch_request,
                input task_count, input create_error, output ready);
endinterface

/* hw/rtl/rrts_core.sv */
// Task table and slot-walking sequencer of the round-robin task scheduler.
// Depends on rrts_pkg and round_robin_task_scheduler_macros.svh.
`timescale 1ns / 1ps

module rrts_core #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rrts_pkg::MODE_W-1:0]  mode,
  input  logic [rrts_pkg::TICKS_W-1:0] delay_ticks,
  input  logic                         take,
  output rrts_pkg::core_sts_t          sts,
  output rrts_pkg::res_t               res
);
  import rrts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_COUNT  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [MAX_TASKS-1:0] blocked_r, blocked_nxt;
  logic [TICKS_W-1:0]   delay_mem [MAX_TASKS];
  logic [TICKS_W-1:0]   dly_rd_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [IDX_W-1:0]     chosen_r, chosen_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     cand_r, cand_nxt;
  logic [CNT_W-1:0]     steps_r, steps_nxt;
  logic                 sw_r, sw_nxt;
  logic                 err_r, err_nxt;

  logic                 dly_we;
  logic [IDX_W-1:0]     dly_addr;
  logic [TICKS_W-1:0]   dly_wdata;
  logic [IDX_W-1:0]     slot;
  logic [TICKS_W-1:0]   dly_dec;
  logic [IDX_W-1:0]     cand_inc;
  logic [IDX_W-1:0]     cur_inc;
  logic [CNT_W-1:0]     count_inc;
  logic [IDX_W+NEXT_W-1:0]  chosen_ext;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic                 create_go;
  logic                 chosen_ok;
  logic                 cur_ok;

  assign slot      = idx_r[IDX_W-1:0];
  assign dly_dec   = dly_rd_r - 1'b1;
  assign cand_inc  = ((CNT_W'(cand_r) + 1'b1) == count_r) ? '0 : cand_r + 1'b1;
  assign cur_inc   = ((CNT_W'(cur_r) + 1'b1) == count_r) ? '0 : cur_r + 1'b1;
  assign count_inc = count_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    blocked_nxt = blocked_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    chosen_nxt  = chosen_r;
    idx_nxt     = idx_r;
    cand_nxt    = cand_r;
    steps_nxt   = steps_r;
    sw_nxt      = sw_r;
    err_nxt     = err_r;
    dly_we      = 1'b0;
    dly_addr    = cur_r;
    dly_wdata   = delay_ticks;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          sw_nxt    = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = ST_DONE;
          unique case (mode)
            MODE_CREATE: begin
              if (count_r < CNT_W'(MAX_TASKS)) begin
                blocked_nxt[count_r[IDX_W-1:0]] = 1'b0;
                count_nxt = count_inc;
              end else begin
                err_nxt = 1'b1;
              end
            end
            MODE_TICK: begin
              if (count_r != '0) begin
                idx_nxt   = '0;
                state_nxt = ST_COUNT;
              end
            end
            MODE_DELAY: begin
              if (delay_ticks != '0) begin
                dly_we             = 1'b1;
                blocked_nxt[cur_r] = 1'b1;
                sw_nxt             = 1'b1;
              end
            end
            MODE_DONE: begin
              cur_nxt = chosen_r;
            end
            default: ;
          endcase
        end
      end
      ST_COUNT: begin
        if (blocked_r[slot] && dly_rd_r != '0) begin
          dly_we    = 1'b1;
          dly_addr  = slot;
          dly_wdata = dly_dec;
          if (dly_dec == '0) begin
            blocked_nxt[slot] = 1'b0;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if ((idx_r + 1'b1) == count_r) begin
          cand_nxt  = cur_inc;
          steps_nxt = '0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!blocked_r[cand_r]) begin
          chosen_nxt = cand_r;
          sw_nxt     = (cand_r != cur_r);
          state_nxt  = ST_DONE;
        end else if (steps_r == count_r - 1'b1) begin
          chosen_nxt = cand_inc;
          sw_nxt     = (cand_inc != cur_r);
          state_nxt  = ST_DONE;
        end else begin
          cand_nxt  = cand_inc;
          steps_nxt = steps_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      blocked_r <= '0;
      count_r   <= '0;
      cur_r     <= '0;
      chosen_r  <= '0;
      sw_r      <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      blocked_r <= blocked_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      chosen_r  <= chosen_nxt;
      sw_r      <= sw_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    cand_r  <= cand_nxt;
    steps_r <= steps_nxt;
  end

  // read the slot that the walk visits next cycle
  always_ff @(posedge clk) begin
    if (dly_we) begin
      delay_mem[dly_addr] <= dly_wdata;
    end
    dly_rd_r <= delay_mem[idx_nxt[IDX_W-1:0]];
  end

  assign chosen_ext         = {{NEXT_W{1'b0}}, chosen_r};
  assign count_ext          = {{COUNT_W{1'b0}}, count_r};
  assign res.next_task      = chosen_ext[NEXT_W-1:0];
  assign res.switch_request = sw_r;
  assign res.task_count     = count_ext[COUNT_W-1:0];
  assign res.create_error   = err_r;
  assign sts.idle           = (state_r == ST_IDLE);
  assign sts.done           = (state_r == ST_DONE);

  assign create_go = start && sts.idle && mode == MODE_CREATE && count_r < CNT_W'(MAX_TASKS);
  assign chosen_ok = (count_r == '0) || (CNT_W'(chosen_r) < count_r);
  assign cur_ok    = (count_r == '0) || (CNT_W'(cur_r) < count_r);

  `include "round_robin_task_scheduler_macros.svh"

  `RRTS_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_TASKS), "count over max")
  `RRTS_ASSERT_IMP(a_chosen_rng, clk, rst_n, 1'b1, chosen_ok, "chosen out of range")
  `RRTS_ASSERT_IMP(a_cur_rng, clk, rst_n, 1'b1, cur_ok, "current out of range")
  `RRTS_ASSERT_IMP(a_walk_rng, clk, rst_n, state_r == ST_COUNT, idx_r < count_r, "walk past count")
  `RRTS_ASSERT_NXT(a_create_inc, clk, rst_n, create_go, count_r == $past(count_inc), "no count step")

endmodule

/* hw/rtl/round_robin_task_scheduler.sv */
// Round-robin task scheduler: one item at a time. Create, delay and switch-done
// items go straight from the idle state to the done state; a tick walks the N
// created tasks, then takes S search steps (1 to N, none without tasks). A single
// decrementer walks the slots one per cycle for the countdown, then one search
// pointer steps round-robin through the ready flags. Input is accepted only while
// the sequencer is idle; a finished result waits in an output register, so the next
// item can be taken meanwhile.
// Depends on rrts_pkg, rrts_in_if, rrts_out_if and rrts_core.
`timescale 1ns / 1ps

module round_robin_task_scheduler #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch
);
  import rrts_pkg::*;

  core_sts_t sts;
  res_t      res;
  res_t      out_res_r;
  logic      out_valid_r;
  logic      take;
  logic      start;

  assign start       = in_ch.valid && in_ch.ready;
  assign in_ch.ready = sts.idle;
  assign take        = sts.done && (!out_valid_r || out_ch.ready);

  rrts_core #(
    .MAX_TASKS (MAX_TASKS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .mode        (in_ch.mode),
    .delay_ticks (in_ch.delay_ticks),
    .take        (take),
    .sts         (sts),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.next_task      = out_res_r.next_task;
  assign out_ch.switch_request = out_res_r.switch_request;
  assign out_ch.task_count     = out_res_r.task_count;
  assign out_ch.create_error   = out_res_r.create_error;

endmodule

/* tb/sv/tb_round_robin_task_scheduler.sv */
// Self-checking testbench for round_robin_task_scheduler: directed table, then random
// tick/switch-done/delay sequences plus any-mode items, scored by a local predictor.
// Depends on rrts_pkg, rrts_in_if, rrts_out_if and the scheduler RTL.
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam int SLOTS        = MAX_TASKS_DEF;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 175;

  typedef struct {
    mode_t              mode;
    logic [TICKS_W-1:0] ticks;
    bit                 typed;
    res_t               want;
  } stim_row_t;

  typedef struct {
    bit   typed;
    res_t want;
  } check_hint_t;

  logic clk;
  logic rst_n;

  rrts_in_if  in_ch ();
  rrts_out_if out_ch ();

  round_robin_task_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // scheduler shadow state
  bit               held [SLOTS];
  bit [TICKS_W-1:0] ticks_left [SLOTS];
  int               made;
  int               cur_task;
  int               pick_task;

  res_t        due_q [$];
  check_hint_t hint_q [$];
  stim_row_t   dir_rows [$];

  int errors;
  int n_results;
  int n_switch;
  int n_refused;
  int n_mode [4];
  int quiet;
  int idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_go;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t sched_step(input mode_t m, input logic [TICKS_W-1:0] t);
    res_t r;
    int   c;
    bit   sw;
    bit   err;
    sw  = 1'b0;
    err = 1'b0;
    case (m)
      MODE_CREATE: begin
        if (made < SLOTS) begin
          held[made]       = 1'b0;
          ticks_left[made] = '0;
          made++;
        end else begin
          err = 1'b1;
        end
      end
      MODE_TICK: begin
        for (int i = 0; i < made; i++) begin
          if (held[i] && ticks_left[i] != 0) begin
            ticks_left[i]--;
            if (ticks_left[i] == 0) held[i] = 1'b0;
          end
        end
        if (made != 0) begin
          c = (cur_task + 1) % made;
          for (int i = 0; i < made && held[c]; i++) c = (c + 1) % made;
          pick_task = c;
          sw = (pick_task != cur_task);
        end
      end
      MODE_DELAY: begin
        if (t != 0) begin
          held[cur_task]       = 1'b1;
          ticks_left[cur_task] = t;
          sw = 1'b1;
        end
      end
      default: cur_task = pick_task;
    endcase
    r.next_task      = pick_task[NEXT_W-1:0];
    r.switch_request = sw;
    r.task_count     = made[COUNT_W-1:0];
    r.create_error   = err;
    return r;
  endfunction

  function automatic res_t mk_res(input int nt, input int sw, input int cnt, input int err);
    res_t r;
    r.next_task      = nt[NEXT_W-1:0];
    r.switch_request = sw[0];
    r.task_count     = cnt[COUNT_W-1:0];
    r.create_error   = err[0];
    return r;
  endfunction

  function automatic void add_row(input mode_t m, input logic [TICKS_W-1:0] t,
                                  input bit typed, input res_t want);
    stim_row_t row;
    row.mode  = m;
    row.ticks = t;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  task automatic report(input string field, input int got, input int want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d",
             n_results, field, got, want);
    errors++;
  endtask

  task automatic offer(input mode_t m, input logic [TICKS_W-1:0] t,
                       input bit typed, input res_t want);
    check_hint_t h;
    h.typed = typed;
    h.want  = want;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    hint_q.push_back(h);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.delay_ticks <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0 || hint_q.size() != 0) @(posedge clk);
  endtask

  // score accepted items and results
  always @(posedge clk) begin
    check_hint_t h;
    res_t        p;
    res_t        w;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        h = hint_q.pop_front();
        p = sched_step(mode_t'(in_ch.mode), in_ch.delay_ticks);
        due_q.push_back(h.typed ? h.want : p);
        n_mode[in_ch.mode]++;
        n_switch  += p.switch_request;
        n_refused += p.create_error;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          w = due_q.pop_front();
          if (out_ch.next_task !== w.next_task)
            report("next_task", out_ch.next_task, w.next_task);
          if (out_ch.switch_request !== w.switch_request)
            report("switch_request", out_ch.switch_request, w.switch_request);
          if (out_ch.task_count !== w.task_count)
            report("task_count", out_ch.task_count, w.task_count);
          if (out_ch.create_error !== w.create_error)
            report("create_error", out_ch.create_error, w.create_error);
        end
        n_results++;
      end
    end
  end

  // result sink: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int          seq_pos;
    int          tick_run;
    int          r;
    mode_t       m;
    logic [31:0] t;
    int          idle_tab [4];
    int          stall_tab [4];

    idle_tab  = '{0, 67, 0, 11};
    stall_tab = '{0, 0, 67, 11};
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_CREATE;
    in_ch.delay_ticks = '0;
    rst_n             = 1'b0;
    hold_go           = 1'b0;
    errors    = 0;
    n_results = 0;
    n_switch  = 0;
    n_refused = 0;
    n_mode    = '{0, 0, 0, 0};
    idle_pct  = 0;
    stall_pct = 0;
    made      = 0;
    cur_task  = 0;
    pick_task = 0;
    foreach (held[i]) begin
      held[i]       = 1'b0;
      ticks_left[i] = '0;
    end

    add_row(MODE_TICK, 0, 1, mk_res(0, 0, 0, 0));
    add_row(MODE_DELAY, 0, 1, mk_res(0, 0, 0, 0));
    add_row(MODE_DELAY, 5, 1, mk_res(0, 1, 0, 0));
    add_row(MODE_DONE, 0, 1, mk_res(0, 0, 0, 0));
    add_row(MODE_CREATE, 0, 1, mk_res(0, 0, 1, 0));
    add_row(MODE_CREATE, 0, 1, mk_res(0, 0, 2, 0));
    add_row(MODE_TICK, 0, 0, '0);
    add_row(MODE_DONE, 0, 0, '0);
    add_row(MODE_DELAY, 1, 0, '0);
    add_row(MODE_TICK, 0, 0, '0);
    add_row(MODE_DONE, 0, 0, '0);
    add_row(MODE_DELAY, 32'hFFFF_FFFF, 0, '0);
    add_row(MODE_TICK, 0, 0, '0);
    add_row(MODE_DONE, 0, 0, '0);
    add_row(MODE_DELAY, 2, 0, '0);
    add_row(MODE_TICK, 0, 0, '0);
    for (int k = 3; k <= SLOTS; k++) add_row(MODE_CREATE, 0, 1, mk_res(0, 0, k, 0));
    add_row(MODE_CREATE, 32'hA5A5_5A5A, 1, mk_res(0, 0, SLOTS, 1));
    add_row(MODE_TICK, 0, 0, '0);
    add_row(MODE_DONE, 0, 0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      offer(dir_rows[i].mode, dir_rows[i].ticks, dir_rows[i].typed, dir_rows[i].want);
    settle();

    seq_pos  = 0;
    tick_run = 1;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      if (ph == 0) hold_go <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 12) begin
          m = mode_t'($urandom_range(3));
          t = (m == MODE_DELAY) ? 32'($urandom_range(8)) : $urandom;
        end else begin
          case (seq_pos)
            0: begin
              m = MODE_TICK;
              t = $urandom;
              tick_run--;
              if (tick_run == 0) seq_pos = 1;
            end
            1: begin
              m = MODE_DONE;
              t = $urandom;
              seq_pos = ($urandom_range(99) < 60) ? 2 : 0;
              tick_run = $urandom_range(1, 3);
            end
            default: begin
              m = MODE_DELAY;
              r = $urandom_range(99);
              if (r < 10) t = 0;
              else if (r < 15) t = $urandom;
              else t = $urandom_range(1, 6);
              seq_pos = 0;
            end
          endcase
        end
        offer(m, t, 1'b0, '0);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d creates (%0d refused), %0d ticks, %0d delays, %0d done.",
             n_mode[MODE_CREATE] + n_mode[MODE_TICK] + n_mode[MODE_DELAY] + n_mode[MODE_DONE],
             n_mode[MODE_CREATE], n_refused, n_mode[MODE_TICK], n_mode[MODE_DELAY],
             n_mode[MODE_DONE]);
    $display("Checked %0d results, %0d with a switch request, %0d mismatches.",
             n_results, n_switch, errors);
    if (errors == 0 && due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
